### hw/rtl/ale_pkg.sv
// Shared types and constants for the array list engine.
`default_nettype none

package ale_pkg;

    localparam int FUNC_BITS   = 3;
    localparam int POS_BITS    = 5;
    localparam int VALUE_BITS  = 32;
    localparam int INDEX_BITS  = 5;
    localparam int STATUS_BITS = 2;

    // Operation selectors.
    localparam logic [FUNC_BITS-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_DELETE = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_GET    = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_LOCATE = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_PRED   = 3'd4;
    localparam logic [FUNC_BITS-1:0] FN_SUCC   = 3'd5;
    localparam logic [FUNC_BITS-1:0] FN_CLEAR  = 3'd6;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SHIFT_UP,
        S_WRITE_NEW,
        S_SHIFT_DN,
        S_SCAN,
        S_FETCH,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic walk_start;
        logic rd;
        logic rd_adj;
        logic wr_up;
        logic wr_dn;
        logic wr_new;
        logic cap_value;
        logic cap_index;
        logic res_ok;
        logic res_full;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 ins_pos_ok;
        logic                 pos_ok;
        logic                 full;
        logic                 multi;
        logic                 left_zero;
        logic                 rd_vld;
        logic                 match;
        logic                 rd_at_pos;
        logic                 out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/ale_dp.sv
// Datapath of the array list engine: storage, walk pointers, result and output registers.
`default_nettype none

module ale_dp
    import ale_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ctrl_cmd_t                     cmd,
    output dp_status_t                         sts,
    input  wire logic        [FUNC_BITS-1:0]   func,
    input  wire logic        [POS_BITS-1:0]    position,
    input  wire logic signed [VALUE_BITS-1:0]  value,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic             [STATUS_BITS-1:0] status,
    output logic signed      [VALUE_BITS-1:0]  value_out,
    output logic             [INDEX_BITS-1:0]  index_out,
    output logic             [INDEX_BITS-1:0]  length_out
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CW > POS_BITS) ? CW : POS_BITS) + 1;
    localparam int EXT_W = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [FUNC_BITS-1:0]   func_reg,   func_next;
    logic [POS_BITS-1:0]    pos_reg,    pos_next;
    logic [WORD_BITS-1:0]   key_reg,    key_next;
    logic [CW-1:0]          count_reg,  count_next;
    logic [CW-1:0]          ptr_reg,    ptr_next;
    logic [CW-1:0]          left_reg,   left_next;
    logic [CW-1:0]          rd_addr_reg, rd_addr_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [WORD_BITS-1:0]   rd_data_reg;
    logic [STATUS_BITS-1:0] rstat_reg,  rstat_next;
    logic [VALUE_BITS-1:0]  rvalue_reg, rvalue_next;
    logic [INDEX_BITS-1:0]  rindex_reg, rindex_next;
    logic                   out_vld_reg, out_vld_next;
    logic [STATUS_BITS-1:0] out_stat_reg;
    logic [VALUE_BITS-1:0]  out_value_reg;
    logic [INDEX_BITS-1:0]  out_index_reg;
    logic [INDEX_BITS-1:0]  out_len_reg;

    logic signed [EXT_W-1:0] value_ext;
    logic [CMP_W-1:0]        pos_x;
    logic [CMP_W-1:0]        cnt_x;
    logic [CW-1:0]           pm1;
    logic [CW-1:0]           rd_addr_inc;
    logic [CW-1:0]           rd_addr_dec;
    logic [CW-1:0]           rd_addr;
    logic                    rd_en;
    logic                    wr_en;
    logic [CW-1:0]           wr_addr;
    logic [WORD_BITS-1:0]    wr_data;
    logic [CW-1:0]           ptr_init;
    logic [CW-1:0]           left_init;

    assign value_ext   = EXT_W'(value);
    assign pos_x       = CMP_W'(pos_reg);
    assign cnt_x       = CMP_W'(count_reg);
    assign pm1         = CW'(pos_x - CMP_W'(1));
    assign rd_addr_inc = rd_addr_reg + CW'(1);
    assign rd_addr_dec = rd_addr_reg - CW'(1);

    // Status toward the controller.
    always_comb
    begin
        sts.func       = func_reg;
        sts.ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
        sts.pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
        sts.full       = (count_reg == CW'(DEPTH));
        sts.multi      = (count_reg >= CW'(2));
        sts.left_zero  = (left_reg == '0);
        sts.rd_vld     = rd_vld_reg;
        sts.match      = (rd_data_reg == key_reg);
        sts.rd_at_pos  = (rd_addr_reg == pm1);
        sts.out_free   = !out_vld_reg || !res_stall;
    end

    // Start point and length of the walk for each operation.
    always_comb
    begin
        ptr_init  = '0;
        left_init = '0;
        unique case (func_reg)
            FN_INSERT:
            begin
                ptr_init  = count_reg - CW'(1);
                left_init = count_reg - pm1;
            end
            FN_DELETE:
            begin
                ptr_init  = pm1;
                left_init = count_reg - pm1;
            end
            FN_GET:
            begin
                ptr_init  = pm1;
                left_init = CW'(1);
            end
            FN_LOCATE:
            begin
                ptr_init  = '0;
                left_init = count_reg;
            end
            FN_PRED:
            begin
                ptr_init  = CW'(1);
                left_init = count_reg - CW'(1);
            end
            FN_SUCC:
            begin
                ptr_init  = '0;
                left_init = count_reg - CW'(1);
            end
            default:
            begin
                ptr_init  = '0;
                left_init = '0;
            end
        endcase
    end

    // Memory port selection.
    always_comb
    begin
        rd_en = cmd.rd || cmd.rd_adj;
        if (cmd.rd_adj)
        begin
            rd_addr = (func_reg == FN_PRED) ? rd_addr_dec : rd_addr_inc;
        end
        else
        begin
            rd_addr = ptr_reg;
        end

        wr_en = cmd.wr_up || cmd.wr_dn || cmd.wr_new;
        priority if (cmd.wr_new)
        begin
            wr_addr = pm1;
            wr_data = key_reg;
        end
        else if (cmd.wr_up)
        begin
            wr_addr = rd_addr_inc;
            wr_data = rd_data_reg;
        end
        else
        begin
            wr_addr = rd_addr_dec;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // Next values of the control and result registers.
    always_comb
    begin
        func_next    = func_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        left_next    = left_reg;
        rd_addr_next = rd_en ? rd_addr : rd_addr_reg;
        rd_vld_next  = rd_en;
        rstat_next   = rstat_reg;
        rvalue_next  = rvalue_reg;
        rindex_next  = rindex_reg;

        if (cmd.load_item)
        begin
            func_next   = func;
            pos_next    = position;
            key_next    = value_ext[WORD_BITS-1:0];
            rstat_next  = ST_MISS;
            rvalue_next = '0;
            rindex_next = '0;
        end

        if (cmd.walk_start)
        begin
            ptr_next  = ptr_init;
            left_next = left_init;
        end
        else if (cmd.rd)
        begin
            ptr_next  = (func_reg == FN_INSERT) ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
            left_next = left_reg - CW'(1);
        end

        priority if (cmd.cnt_clr)
        begin
            count_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        if (cmd.res_ok)
        begin
            rstat_next = ST_OK;
        end
        if (cmd.res_full)
        begin
            rstat_next = ST_FULL;
        end
        if (cmd.cap_value)
        begin
            rvalue_next = VALUE_BITS'(rd_data_reg);
        end
        if (cmd.cap_index)
        begin
            rindex_next = INDEX_BITS'(rd_addr_inc);
        end
    end

    assign out_vld_next = cmd.out_load ? 1'b1 : (res_stall ? out_vld_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            left_reg    <= '0;
            ptr_reg     <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            func_reg    <= FN_CLEAR;
        end
        else
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            ptr_reg     <= ptr_next;
            rd_addr_reg <= rd_addr_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
            func_reg    <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        rstat_reg  <= rstat_next;
        rvalue_reg <= rvalue_next;
        rindex_reg <= rindex_next;
        if (cmd.out_load)
        begin
            out_stat_reg  <= rstat_reg;
            out_value_reg <= rvalue_reg;
            out_index_reg <= rindex_reg;
            out_len_reg   <= INDEX_BITS'(count_reg);
        end
    end

    assign res_valid  = out_vld_reg;
    assign status     = out_stat_reg;
    assign value_out  = out_value_reg;
    assign index_out  = out_index_reg;
    assign length_out = out_len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list length above capacity");

    a_port_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write to the same entry in one cycle");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.cnt_inc || !sts.full) && (!cmd.cnt_dec || (count_reg != '0)))
        else $error("list length wraps");

endmodule

`default_nettype wire

### hw/rtl/ale_ctrl.sv
// Controller state machine of the array list engine.
`default_nettype none

module ale_ctrl
    import ale_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   hit;

    assign hit = sts.rd_vld && sts.match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.func)
                    FN_INSERT:
                        state_next = (sts.ins_pos_ok && !sts.full) ? S_SHIFT_UP : S_FINISH;
                    FN_DELETE, FN_GET:
                        state_next = sts.pos_ok ? S_SHIFT_DN : S_FINISH;
                    FN_LOCATE:
                        state_next = S_SCAN;
                    FN_PRED, FN_SUCC:
                        state_next = sts.multi ? S_SCAN : S_FINISH;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_SHIFT_UP:
            begin
                if (sts.left_zero)
                begin
                    state_next = S_WRITE_NEW;
                end
            end
            S_WRITE_NEW:
            begin
                state_next = S_FINISH;
            end
            S_SHIFT_DN:
            begin
                if (sts.left_zero)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = (sts.func == FN_LOCATE) ? S_FINISH : S_FETCH;
                end
                else if (sts.left_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_FETCH:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd       = '0;
        req_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = req_valid;
            end
            S_DISPATCH:
            begin
                unique case (sts.func)
                    FN_INSERT:
                    begin
                        cmd.res_full   = sts.ins_pos_ok && sts.full;
                        cmd.walk_start = sts.ins_pos_ok && !sts.full;
                    end
                    FN_DELETE, FN_GET:
                        cmd.walk_start = sts.pos_ok;
                    FN_LOCATE:
                        cmd.walk_start = 1'b1;
                    FN_PRED, FN_SUCC:
                        cmd.walk_start = sts.multi;
                    FN_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        cmd.res_ok  = 1'b1;
                    end
                    default:
                        cmd.res_ok = 1'b0;
                endcase
            end
            S_SHIFT_UP:
            begin
                cmd.wr_up = sts.rd_vld;
                cmd.rd    = !sts.left_zero;
            end
            S_WRITE_NEW:
            begin
                cmd.wr_new  = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.res_ok  = 1'b1;
            end
            S_SHIFT_DN:
            begin
                cmd.rd        = !sts.left_zero;
                cmd.cap_value = sts.rd_vld && sts.rd_at_pos;
                cmd.wr_dn     = sts.rd_vld && !sts.rd_at_pos && (sts.func == FN_DELETE);
                cmd.res_ok    = sts.left_zero;
                cmd.cnt_dec   = sts.left_zero && (sts.func == FN_DELETE);
            end
            S_SCAN:
            begin
                cmd.cap_index = hit && (sts.func == FN_LOCATE);
                cmd.res_ok    = hit && (sts.func == FN_LOCATE);
                cmd.rd_adj    = hit && (sts.func != FN_LOCATE);
                cmd.rd        = !hit && !sts.left_zero;
            end
            S_FETCH:
            begin
                cmd.cap_value = 1'b1;
                cmd.res_ok    = 1'b1;
            end
            S_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
        endcase
    end

    a_delete_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_DN && sts.left_zero) |-> sts.rd_vld)
        else $error("removal walk ends without the last word read");

    a_fetch_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> sts.rd_vld)
        else $error("neighbor fetch without read data");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_up, cmd.wr_dn, cmd.wr_new}))
        else $error("more than one memory write in a cycle");

endmodule

`default_nettype wire

### hw/rtl/array_list_engine_core.sv
// Top level of the array list engine: a bounded ordered list of signed words.
//
// A request carries func, position and value and is taken at a rising edge where
// req_valid is high and req_stall is low. Each request yields exactly one result
// (status, value_out, index_out, length_out) on the result channel, handed over at
// an edge where res_valid is high and res_stall is low.
// The list lives in a DEPTH-entry single-write, single-read memory. Insert, delete
// and the searches walk it one entry per cycle through the memory read port.
// The result becomes valid when req_stall drops for the next request.
// One request is worked on at a time; req_stall is high while it is in progress.
// The finished result sits in an output register, so a new request is taken while
// the previous result still waits. If res_stall keeps that register full, the
// next result waits inside the block and req_stall stays high meanwhile.
// Reset empties the list at once (length zero); the stored words are not cleared,
// as no position beyond the length can be read.
`default_nettype none

module array_list_engine_core
    import ale_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic        [FUNC_BITS-1:0]   func,
    input  wire logic        [POS_BITS-1:0]    position,
    input  wire logic signed [VALUE_BITS-1:0]  value,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic             [STATUS_BITS-1:0] status,
    output logic signed      [VALUE_BITS-1:0]  value_out,
    output logic             [INDEX_BITS-1:0]  index_out,
    output logic             [INDEX_BITS-1:0]  length_out
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // The controller sequences each request; the datapath holds the list.
    ale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ale_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .func       (func),
        .position   (position),
        .value      (value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .value_out  (value_out),
        .index_out  (index_out),
        .length_out (length_out)
    );

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the array list engine: directed and random list operations.

module tb;
    import ale_pkg::*;

    localparam int DEPTH        = 16;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // The package names no selector for code seven, which the block must refuse.
    localparam logic [FUNC_BITS-1:0] FN_UNDEFINED = 3'd7;

    localparam logic signed [VALUE_BITS-1:0] WORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VALUE_BITS-1:0] WORD_MIN = 32'sh80000000;
    localparam logic signed [VALUE_BITS-1:0] WORD_M1  = 32'shFFFFFFFF;

    // One result as the block reports it.
    typedef struct packed {
        logic [STATUS_BITS-1:0]       status;
        logic signed [VALUE_BITS-1:0] word;
        logic [INDEX_BITS-1:0]        index;
        logic [INDEX_BITS-1:0]        length;
    } list_result_t;

    // Scoreboard: keeps its own copy of the list, works out the answer to every
    // accepted request and holds those answers until the block reports them.
    class list_scoreboard;
        logic signed [VALUE_BITS-1:0] words[DEPTH];
        int unsigned                  count;
        list_result_t                 pending_results[$];
        int unsigned                  fails;

        function new();
            count = 0;
            fails = 0;
        endfunction

        function int unsigned length();
            return count;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void note_request(logic [FUNC_BITS-1:0] f, logic [POS_BITS-1:0] p,
                                   logic signed [VALUE_BITS-1:0] v);
            list_result_t r;
            int           k;
            int           pos;
            r.status = ST_MISS;
            r.word   = '0;
            r.index  = '0;
            pos      = p;
            case (f)
                FN_INSERT:
                begin
                    // Range is checked before fullness.
                    if (pos >= 1 && pos <= count + 1) begin
                        if (count >= DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            for (k = count; k >= pos; k--)
                                words[k] = words[k-1];
                            words[pos-1] = v;
                            count++;
                            r.status = ST_OK;
                        end
                    end
                end
                FN_DELETE:
                begin
                    if (pos >= 1 && pos <= count) begin
                        r.word = words[pos-1];
                        for (k = pos; k < count; k++)
                            words[k-1] = words[k];
                        count--;
                        r.status = ST_OK;
                    end
                end
                FN_GET:
                begin
                    if (pos >= 1 && pos <= count) begin
                        r.word   = words[pos-1];
                        r.status = ST_OK;
                    end
                end
                FN_LOCATE:
                begin
                    for (k = 0; k < count; k++) begin
                        if (r.status != ST_OK && words[k] == v) begin
                            r.index  = INDEX_BITS'(k + 1);
                            r.status = ST_OK;
                        end
                    end
                end
                FN_PRED:
                begin
                    // Only positions two onward can have a predecessor.
                    for (k = 1; k < count; k++) begin
                        if (r.status != ST_OK && words[k] == v) begin
                            r.word   = words[k-1];
                            r.status = ST_OK;
                        end
                    end
                end
                FN_SUCC:
                begin
                    // The last position has no successor.
                    for (k = 0; k + 1 < count; k++) begin
                        if (r.status != ST_OK && words[k] == v) begin
                            r.word   = words[k+1];
                            r.status = ST_OK;
                        end
                    end
                end
                FN_CLEAR:
                begin
                    count    = 0;
                    r.status = ST_OK;
                end
                default:
                begin
                    r.status = ST_MISS;
                end
            endcase
            r.length = count[INDEX_BITS-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (pending_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.word !== want.word) begin
                $error("value_out: expected %0d, got %0d", want.word, got.word);
                fails++;
            end
            if (got.index !== want.index) begin
                $error("index_out: expected %0d, got %0d", want.index, got.index);
                fails++;
            end
            if (got.length !== want.length) begin
                $error("length_out: expected %0d, got %0d", want.length, got.length);
                fails++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_stall;
    logic [FUNC_BITS-1:0]          func;
    logic [POS_BITS-1:0]           position;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          res_valid;
    logic                          res_stall;
    logic [STATUS_BITS-1:0]        status;
    logic signed [VALUE_BITS-1:0]  value_out;
    logic [INDEX_BITS-1:0]         index_out;
    logic [INDEX_BITS-1:0]         length_out;

    list_scoreboard sb;

    // Idling controls; the receiver's are set by the stimulus thread with nonblocking
    // writes, so it never sees them at the edge they are written, whatever the order.
    int unsigned sender_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_token;
    int unsigned seen_token;
    int unsigned hold_left;
    int unsigned cycles;

    // Small pool of words so that searches hit stored entries and duplicates.
    logic signed [VALUE_BITS-1:0] word_pool[8];

    array_list_engine_core #(
        .DEPTH     (DEPTH),
        .WORD_BITS (VALUE_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .position   (position),
        .value      (value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .value_out  (value_out),
        .index_out  (index_out),
        .length_out (length_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side. A result counts at an edge where res_valid is high and our
    // own stall was low; the stall for the next cycle is chosen afterward. A long
    // hold-off is started each time the stimulus thread bumps hold_token.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result('{status, value_out, index_out, length_out});
        if (hold_token != seen_token) begin
            seen_token <= hold_token;
            hold_left  <= HOLD_CYCLES;
            res_stall  <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high so that back-to-back requests never drop it in between.
    task automatic send_request(input logic [FUNC_BITS-1:0] f, input logic [POS_BITS-1:0] p,
                                input logic signed [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        position  <= p;
        value     <= v;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(f, p, v);
    endtask

    // The sender goes quiet until every result is back, then lets the block settle.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [FUNC_BITS-1:0] pick_func(input bit fill_bias);
        int unsigned r;
        r = $urandom_range(99);
        if (fill_bias) begin
            if (r < 70)
                return FN_INSERT;
            r = $urandom_range(99);
        end
        if (r < 30)
            return FN_INSERT;
        else if (r < 45)
            return FN_DELETE;
        else if (r < 57)
            return FN_GET;
        else if (r < 69)
            return FN_LOCATE;
        else if (r < 81)
            return FN_PRED;
        else if (r < 93)
            return FN_SUCC;
        else if (r < 97)
            return FN_CLEAR;
        else
            return FN_UNDEFINED;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_word();
        if ($urandom_range(99) < 75)
            return word_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic logic [POS_BITS-1:0] pick_position();
        // Mostly near the live part of the list, sometimes anywhere.
        if ($urandom_range(99) < 80)
            return POS_BITS'($urandom_range(sb.length() + 1, 0));
        return POS_BITS'($urandom_range(31, 0));
    endfunction

    // Random phases: request count, sender idle and receiver stall percentages,
    // a bias toward inserts that drives the list to full, and a receiver hold-off.
    int unsigned phase_items[7] = '{200, 200, 200, 250, 150, 150, 250};
    int unsigned phase_idle[7]  = '{0, 85, 0, 21, 0, 0, 0};
    int unsigned phase_stall[7] = '{0, 0, 85, 21, 0, 0, 0};
    bit          phase_fill[7]  = '{0, 0, 0, 0, 1, 0, 0};
    bit          phase_hold[7]  = '{0, 0, 0, 0, 0, 1, 0};

    initial
    begin
        int ph;
        int n;
        sb              = new();
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        func            = FN_GET;
        position        = '0;
        value           = '0;
        res_stall       = 1'b0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_token      = 0;
        seen_token      = 0;
        hold_left       = 0;
        cycles          = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty list, range edges, extreme words, duplicates,
        // searches at both ends, the refused selector and clear.
        send_request(FN_GET,    5'd1,  32'sd0);
        send_request(FN_DELETE, 5'd1,  32'sd0);
        send_request(FN_LOCATE, 5'd0,  32'sd0);
        send_request(FN_PRED,   5'd0,  32'sd0);
        send_request(FN_SUCC,   5'd0,  32'sd0);
        send_request(FN_INSERT, 5'd0,  32'sd5);
        send_request(FN_INSERT, 5'd2,  32'sd5);
        send_request(FN_INSERT, 5'd1,  WORD_MAX);
        send_request(FN_SUCC,   5'd0,  WORD_MAX);
        send_request(FN_INSERT, 5'd2,  WORD_MIN);
        send_request(FN_INSERT, 5'd1,  32'sd0);
        send_request(FN_INSERT, 5'd4,  WORD_M1);
        send_request(FN_INSERT, 5'd2,  WORD_MAX);
        send_request(FN_LOCATE, 5'd31, WORD_MAX);
        // The first word has nothing before it, and the last nothing after it.
        send_request(FN_PRED,   5'd0,  32'sd0);
        send_request(FN_PRED,   5'd0,  WORD_MAX);
        send_request(FN_SUCC,   5'd0,  WORD_M1);
        send_request(FN_SUCC,   5'd0,  WORD_MAX);
        send_request(FN_GET,    5'd31, 32'sd0);
        send_request(FN_GET,    5'd5,  32'sd0);
        send_request(FN_DELETE, 5'd3,  32'sd0);
        send_request(FN_DELETE, 5'd5,  32'sd0);
        send_request(FN_UNDEFINED, 5'd1, WORD_M1);
        send_request(FN_GET,    5'd0,  32'sd0);
        send_request(FN_CLEAR,  5'd0,  32'sd0);
        send_request(FN_GET,    5'd1,  32'sd0);
        wait_for_results();

        for (ph = 0; ph < 7; ph++) begin
            word_pool[0] = 32'sd0;
            word_pool[1] = WORD_M1;
            word_pool[2] = WORD_MIN;
            word_pool[3] = WORD_MAX;
            for (n = 4; n < 8; n++)
                word_pool[n] = $urandom;
            sender_idle_pct = phase_idle[ph];
            stall_pct      <= phase_stall[ph];
            // The hold-off stalls the result side while the sender keeps offering,
            // so the block backs up and holds its request side stalled.
            if (phase_hold[ph])
                hold_token <= hold_token + 1;
            for (n = 0; n < phase_items[ph]; n++)
                send_request(pick_func(phase_fill[ph]), pick_position(), pick_word());
            wait_for_results();
        end

        if (sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ale_pkg.sv
hw/rtl/ale_dp.sv
hw/rtl/ale_ctrl.sv
hw/rtl/array_list_engine_core.sv
sim/tb.sv
